// ----- design/hpr_pkg.sv -----
// ----------------------------------------------------------------------------
// HDR pixel converter package
// Shared types, register indexes, matrix and luma coefficients, helpers.
// ----------------------------------------------------------------------------
package hpr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FIX_W     = 40;
   localparam int CSHIFT    = 20;
   localparam int COEF_W    = 23;
   localparam int SPLIT     = 20;
   localparam int PLO_W     = COEF_W + SPLIT + 1;
   localparam int PHI_W     = COEF_W + FIX_W - SPLIT;
   localparam int SLO_W     = PLO_W + 2;
   localparam int SHI_W     = PHI_W + 2;
   localparam int ACC_W     = SHI_W + CSHIFT + 3;
   localparam int IDX_W     = 3;
   localparam int CSR_W     = 5;
   localparam int MAX_BITS  = 16;
   localparam int INTP_W    = MAX_BITS + FRAC_BITS;

   typedef logic signed [FIX_W-1:0]  fix_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PLO_W-1:0]  plo_type;
   typedef logic signed [PHI_W-1:0]  phi_type;
   typedef logic signed [SLO_W-1:0]  slo_type;
   typedef logic signed [SHI_W-1:0]  shi_type;
   typedef logic [FRAC_BITS-1:0]     gain_type;
   typedef gain_type                 gain_tbl_type [MAX_BITS+1];
   typedef logic [4:0]               rem_tbl_type [MAX_BITS+1];

   typedef struct packed {
      fix_type val;
      logic    warn;
   } fixw_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_THREE = 3'd0,
      CSR_FLOAT = 3'd1,
      CSR_BIGE  = 3'd2,
      CSR_XYZ   = 3'd3,
      CSR_BITS  = 3'd4
   } csr_idx_type;

   localparam fix_type QMAX    = {1'b0, {(FIX_W-1){1'b1}}};
   localparam fix_type QMIN    = {1'b1, {(FIX_W-1){1'b0}}};
   localparam fix_type FIX_ONE = fix_type'(64'sd1 <<< FRAC_BITS);

   localparam coef_type XYZ_MAT [9] = '{
       23'sd3397863, -23'sd1611807,  -23'sd522748,
      -23'sd1016349,  23'sd1967140,    23'sd43575,
         23'sd58346,  -23'sd213937,  23'sd1108345
   };
   localparam coef_type LUMA_W [3] = '{23'sd222927, 23'sd749942, 23'sd75707};

   function automatic gain_tbl_type build_gain();
      gain_tbl_type t;
      longint g;
      int q;
      int r;
      t[0] = '0;
      for (int n = 1; n <= MAX_BITS; n++) begin
         q = 0;
         r = FRAC_BITS;
         while (r >= n) begin
            r = r - n;
            q = q + 1;
         end
         g = 0;
         for (int j = 0; j < q; j++) g = g + (longint'(1) << (j * n));
         t[n] = gain_type'(g << r);
      end
      return t;
   endfunction

   function automatic rem_tbl_type build_rem();
      rem_tbl_type t;
      int r;
      t[0] = '0;
      for (int n = 1; n <= MAX_BITS; n++) begin
         r = FRAC_BITS;
         while (r >= n) r = r - n;
         t[n] = 5'(r);
      end
      return t;
   endfunction

   localparam gain_tbl_type GAIN_TBL = build_gain();
   localparam rem_tbl_type  REM_TBL  = build_rem();

   function automatic fixw_type float_to_fix(logic [31:0] w);
      fixw_type         res;
      logic [7:0]       e;
      logic [22:0]      m;
      logic [23:0]      mant;
      logic signed [10:0] sh;
      logic [10:0]      k;
      logic [25:0]      rnd;
      e = w[30:23];
      m = w[22:0];
      mant = {(e != 8'd0), m};
      sh = 11'(signed'({3'b0, (e != 8'd0) ? e : 8'd1})) - 11'sd150 + 11'(FRAC_BITS);
      k = 11'(-sh);
      rnd = 26'(mant) + (26'd1 << (k[4:0] - 5'd1));
      res.warn = 1'b0;
      res.val  = '0;
      if (e == 8'hFF && m != '0) begin
         res.warn = 1'b1;
         res.val  = QMAX;
      end else if (w[31]) begin
         res.warn = (w[30:0] != '0);
      end else if (e == 8'hFF) begin
         res.warn = 1'b1;
         res.val  = QMAX;
      end else if (mant == '0) begin
         res.val = '0;
      end else if (sh >= 11'sd16) begin
         res.warn = 1'b1;
         res.val  = QMAX;
      end else if (sh >= 11'sd0) begin
         res.val = fix_type'({16'b0, mant} << sh[3:0]);
      end else if (k >= 11'd26) begin
         res.val = '0;
      end else begin
         res.val = fix_type'(rnd >> k[4:0]);
      end
      return res;
   endfunction

   function automatic fixw_type dot_round(shi_type hi, slo_type lo);
      fixw_type res;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] rs;
      acc = (ACC_W'(hi) <<< SPLIT) + ACC_W'(lo) + (ACC_W'(1) <<< (CSHIFT - 1));
      rs  = acc >>> CSHIFT;
      res.warn = 1'b0;
      res.val  = fix_type'(rs);
      if (rs > ACC_W'(QMAX)) begin
         res.warn = 1'b1;
         res.val  = QMAX;
      end else if (rs < ACC_W'(QMIN)) begin
         res.warn = 1'b1;
         res.val  = QMIN;
      end
      return res;
   endfunction

endpackage

// ----- design/hdr_pixel_to_rgb_luma.sv -----
// ----------------------------------------------------------------------------
// HDR pixel to RGB and luma converter
// Raw integer or float samples in, fixed point RGB plus Rec.709 luma out.
// ----------------------------------------------------------------------------
// Input channel req_*: one pixel per beat, three 32-bit raw samples (only the
// first for grey pixels). Result channel rsp_*: red, green, blue and luma in
// signed fixed point with FRAC_BITS fraction bits, plus a warn flag.
// Both channels move a beat when valid is high and stall is low.
// The eight register stages are: sample decode, integer normalize, matrix
// partial products, partial sums, round/saturate, luma partial products, luma
// sums, output. Throughput is one pixel per clock while the result channel is
// not stalled; each stage holds its beat only while the stage after it is full
// and held, so a stalled result back-pressures the input only once every stage
// is occupied.
// The csr_* port writes the mode registers; write only when the block is idle.
// Reset empties the pipeline and returns registers to colour, integer, 8-bit,
// big-endian, RGB input.
// ----------------------------------------------------------------------------
module hdr_pixel_to_rgb_luma (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [31:0]                 req_sample_first,
   input  logic [31:0]                 req_sample_second,
   input  logic [31:0]                 req_sample_third,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output hpr_pkg::fix_type            rsp_red,
   output hpr_pkg::fix_type            rsp_green,
   output hpr_pkg::fix_type            rsp_blue,
   output hpr_pkg::fix_type            rsp_luma,
   output logic                        rsp_warn,
   input  logic                        csr_wr_en,
   input  logic [hpr_pkg::IDX_W-1:0]   csr_index,
   input  logic [hpr_pkg::CSR_W-1:0]   csr_wdata
);
   import hpr_pkg::*;

   localparam int NSTG = 8;

   logic            three_ff, float_ff, bige_ff, xyz_ff;
   logic [4:0]      bits_ff;

   logic [NSTG:1]   vld_ff;
   logic [NSTG:1]   en;

   fix_type         s1_fval_ff [3];
   logic [2:0]      s1_fwarn_ff;
   logic [31:0]     s1_m_ff [3];
   logic [INTP_W-1:0] s1_p_ff [3];

   fix_type         s2_smp_ff [3];
   logic            s2_warn_ff;

   plo_type         s3_plo_ff [9];
   phi_type         s3_phi_ff [9];
   fix_type         s3_smp_ff [3];
   logic            s3_warn_ff;

   slo_type         s4_lo_ff [3];
   shi_type         s4_hi_ff [3];
   fix_type         s4_smp_ff [3];
   logic            s4_warn_ff;

   fix_type         s5_rgb_ff [3];
   logic            s5_warn_ff;

   plo_type         s6_plo_ff [3];
   phi_type         s6_phi_ff [3];
   fix_type         s6_rgb_ff [3];
   logic            s6_warn_ff;

   slo_type         s7_lo_ff;
   shi_type         s7_hi_ff;
   fix_type         s7_rgb_ff [3];
   logic            s7_warn_ff;

   fix_type         out_rgb_ff [3];
   fix_type         out_luma_ff;
   logic            out_warn_ff;

   logic [4:0]      nb;
   logic [16:0]     maxv;
   logic [31:0]     raw [3];
   logic [31:0]     fw [3];
   fixw_type        fdec [3];
   logic [15:0]     iv [3];
   logic [31:0]     m_in [3];
   logic [INTP_W-1:0] p_in [3];
   fix_type         smp_in [3];
   logic            warn2_in;
   fixw_type        mat_res [3];
   fix_type         rgb_in [3];
   logic            warn5_in;
   fixw_type        luma_res;

   // handshake: a stage takes a beat when it is empty or the next one moves
   always_comb begin
      en[NSTG] = !vld_ff[NSTG] || !rsp_stall;
      for (int k = NSTG - 1; k >= 1; k--) en[k] = !vld_ff[k] || en[k+1];
   end

   assign req_stall = !en[1];
   assign rsp_valid = vld_ff[NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = NSTG; k >= 2; k--) if (en[k]) vld_ff[k] <= vld_ff[k-1];
         if (en[1]) vld_ff[1] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         three_ff <= 1'b1;
         float_ff <= 1'b0;
         bige_ff  <= 1'b1;
         xyz_ff   <= 1'b0;
         bits_ff  <= 5'd8;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_THREE: three_ff <= csr_wdata[0];
            CSR_FLOAT: float_ff <= csr_wdata[0];
            CSR_BIGE:  bige_ff  <= csr_wdata[0];
            CSR_XYZ:   xyz_ff   <= csr_wdata[0];
            CSR_BITS:  bits_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: float decode, integer reciprocal split
   always_comb begin
      nb = (bits_ff == 5'd0) ? 5'd1 : (bits_ff > 5'd16) ? 5'd16 : bits_ff;
      maxv = (17'd1 << nb) - 17'd1;
      raw[0] = req_sample_first;
      raw[1] = req_sample_second;
      raw[2] = req_sample_third;
      for (int i = 0; i < 3; i++) begin
         fw[i] = bige_ff ? raw[i] : {raw[i][7:0], raw[i][15:8], raw[i][23:16], raw[i][31:24]};
         fdec[i] = float_to_fix(fw[i]);
         iv[i] = raw[i][15:0] & maxv[15:0];
         m_in[i] = ({16'b0, iv[i]} << REM_TBL[nb]) + 32'(maxv >> 1);
         p_in[i] = INTP_W'(iv[i]) * INTP_W'(GAIN_TBL[nb]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            s1_fval_ff[i]  <= fdec[i].val;
            s1_fwarn_ff[i] <= fdec[i].warn;
            s1_m_ff[i]     <= m_in[i];
            s1_p_ff[i]     <= p_in[i];
         end
      end
   end

   // stage 2: finish integer normalize, pick sample source
   always_comb begin
      logic [31:0] a;
      logic [32:0] ssum;
      logic [1:0]  qc;
      for (int i = 0; i < 3; i++) begin
         a = s1_m_ff[i] >> nb;
         ssum = 33'(a) + 33'(s1_m_ff[i] & {15'b0, maxv});
         qc = (ssum >= (33'(maxv) << 1)) ? 2'd2 : (ssum >= 33'(maxv)) ? 2'd1 : 2'd0;
         smp_in[i] = float_ff ? s1_fval_ff[i]
                              : fix_type'(FIX_W'(s1_p_ff[i]) + FIX_W'(a) + FIX_W'(qc));
      end
      warn2_in = float_ff && (s1_fwarn_ff[0] ||
                 (three_ff && (s1_fwarn_ff[1] || s1_fwarn_ff[2])));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_smp_ff  <= smp_in;
         s2_warn_ff <= warn2_in;
      end
   end

   // stage 3: matrix partial products
   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               s3_plo_ff[3*r+c] <= XYZ_MAT[3*r+c] * $signed({1'b0, s2_smp_ff[c][SPLIT-1:0]});
               s3_phi_ff[3*r+c] <= XYZ_MAT[3*r+c] * $signed(s2_smp_ff[c][FIX_W-1:SPLIT]);
            end
         end
         s3_smp_ff  <= s2_smp_ff;
         s3_warn_ff <= s2_warn_ff;
      end
   end

   // stage 4: partial sums
   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int r = 0; r < 3; r++) begin
            s4_lo_ff[r] <= SLO_W'(s3_plo_ff[3*r]) + SLO_W'(s3_plo_ff[3*r+1])
                         + SLO_W'(s3_plo_ff[3*r+2]);
            s4_hi_ff[r] <= SHI_W'(s3_phi_ff[3*r]) + SHI_W'(s3_phi_ff[3*r+1])
                         + SHI_W'(s3_phi_ff[3*r+2]);
         end
         s4_smp_ff  <= s3_smp_ff;
         s4_warn_ff <= s3_warn_ff;
      end
   end

   // stage 5: round, saturate, select RGB
   always_comb begin
      warn5_in = s4_warn_ff;
      for (int r = 0; r < 3; r++) begin
         mat_res[r] = dot_round(s4_hi_ff[r], s4_lo_ff[r]);
         rgb_in[r]  = s4_smp_ff[r];
      end
      if (!three_ff) begin
         for (int r = 0; r < 3; r++) rgb_in[r] = s4_smp_ff[0];
      end else if (xyz_ff) begin
         for (int r = 0; r < 3; r++) begin
            rgb_in[r] = mat_res[r].val;
            if (mat_res[r].warn) warn5_in = 1'b1;
            if (!float_ff && (mat_res[r].val < 0 || mat_res[r].val > FIX_ONE))
               warn5_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_rgb_ff  <= rgb_in;
         s5_warn_ff <= warn5_in;
      end
   end

   // stage 6: luma partial products
   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int c = 0; c < 3; c++) begin
            s6_plo_ff[c] <= LUMA_W[c] * $signed({1'b0, s5_rgb_ff[c][SPLIT-1:0]});
            s6_phi_ff[c] <= LUMA_W[c] * $signed(s5_rgb_ff[c][FIX_W-1:SPLIT]);
         end
         s6_rgb_ff  <= s5_rgb_ff;
         s6_warn_ff <= s5_warn_ff;
      end
   end

   // stage 7: luma sums
   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_lo_ff <= SLO_W'(s6_plo_ff[0]) + SLO_W'(s6_plo_ff[1]) + SLO_W'(s6_plo_ff[2]);
         s7_hi_ff <= SHI_W'(s6_phi_ff[0]) + SHI_W'(s6_phi_ff[1]) + SHI_W'(s6_phi_ff[2]);
         s7_rgb_ff  <= s6_rgb_ff;
         s7_warn_ff <= s6_warn_ff;
      end
   end

   // stage 8: output register
   assign luma_res = dot_round(s7_hi_ff, s7_lo_ff);

   always_ff @(posedge clock) begin
      if (en[8]) begin
         out_rgb_ff  <= s7_rgb_ff;
         out_luma_ff <= luma_res.val;
         out_warn_ff <= s7_warn_ff || luma_res.warn;
      end
   end

   assign rsp_red   = out_rgb_ff[0];
   assign rsp_green = out_rgb_ff[1];
   assign rsp_blue  = out_rgb_ff[2];
   assign rsp_luma  = out_luma_ff;
   assign rsp_warn  = out_warn_ff;

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (vld_ff == '1 && rsp_stall))
      else $error("input held while pipeline has room");

   a_grey_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !three_ff) |-> (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("grey pixel with unequal channels");

   a_float_rgb_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && float_ff && !xyz_ff) |-> (!rsp_red[FIX_W-1] && !rsp_luma[FIX_W-1]))
      else $error("negative value on float RGB path");

endmodule
